[sv/ipv6_extension_header_skipper_assert.svh]
// assertion macros for the rtl
`ifndef IPV6_EXTENSION_HEADER_SKIPPER_ASSERT_SVH
`define IPV6_EXTENSION_HEADER_SKIPPER_ASSERT_SVH

// plain property checked on every rising clock edge outside reset
`define IPV6EHS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define IPV6EHS_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[sv/ipv6ehs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6ehs_pkg
// Types, codes and helpers for the ipv6 extension header skipper.
// ----------------------------------------------------------------------------
package ipv6ehs_pkg;

   localparam int OffsetBits = 16;
   localparam logic [OffsetBits-1:0] MaxLen = {OffsetBits{1'b1}};
   localparam logic [OffsetBits:0] FixedHdrLen = (OffsetBits + 1)'(40);
   localparam logic [OffsetBits-1:0] NextHdrIndex = OffsetBits'(6);

   // next-header codes
   localparam logic [7:0] NhHopByHop = 8'd0;
   localparam logic [7:0] NhRouting  = 8'd43;
   localparam logic [7:0] NhFragment = 8'd44;
   localparam logic [7:0] NhAuth     = 8'd51;
   localparam logic [7:0] NhNoNext   = 8'd59;
   localparam logic [7:0] NhDestOpts = 8'd60;

   // parse phases
   localparam logic [1:0] PhWait6    = 2'd0;
   localparam logic [1:0] PhWaitType = 2'd1;
   localparam logic [1:0] PhWaitLen  = 2'd2;
   localparam logic [1:0] PhDone     = 2'd3;

   // result status codes
   localparam logic [1:0] StOk     = 2'd0;
   localparam logic [1:0] StTrunc  = 2'd1;
   localparam logic [1:0] StNoNext = 2'd2;

   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       last_byte;
   } ipv6ehs_req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [7:0]            upper_protocol;
      logic [OffsetBits-1:0] payload_offset;
   } ipv6ehs_rsp_type;

   typedef struct packed {
      logic [OffsetBits-1:0] byte_index;
      logic [OffsetBits:0]   chain_pos;
      logic [7:0]            pending_type;
      logic [7:0]            current_type;
      logic [1:0]            parse_phase;
      logic [1:0]            sticky_error;
   } ipv6ehs_state_type;

   localparam ipv6ehs_state_type StateReset = '{
      byte_index:   '0,
      chain_pos:    FixedHdrLen,
      pending_type: 8'd0,
      current_type: 8'd0,
      parse_phase:  PhWait6,
      sticky_error: StOk
   };

   function automatic logic is_ext_type(input logic [7:0] t);
      return (t == NhHopByHop) || (t == NhRouting) || (t == NhFragment) ||
             (t == NhAuth) || (t == NhNoNext) || (t == NhDestOpts);
   endfunction

endpackage

[sv/ipv6_extension_header_skipper.sv]
`timescale 1ns / 1ps
// The final byte is held in the input register; its result then goes to the
// result register on rsp_. Throughput: one packet byte per cycle unless a
// final byte waits for room there; an input register feeds the chain walker,
// whose compare and offset add finish before the result register. The input
// stage advances while a finished result waits, unless it holds a final byte.
// Reset: synchronous, clears both valid flags and returns the walker to byte 0.
// ----------------------------------------------------------------------------
// ipv6_extension_header_skipper
// Walks the ipv6 extension header chain and reports the upper-layer protocol.
// ----------------------------------------------------------------------------
`include "ipv6_extension_header_skipper_assert.svh"

module ipv6_extension_header_skipper import ipv6ehs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ipv6ehs_req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ipv6ehs_rsp_type rsp_data
);

   logic              in_valid_ff;
   logic              in_valid_in;
   ipv6ehs_req_type   in_data_ff;
   ipv6ehs_state_type state_ff;
   ipv6ehs_state_type state_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   ipv6ehs_rsp_type   out_data_ff;
   ipv6ehs_rsp_type   step_rsp;
   logic              advance;

   ipv6ehs_step u_step (
      .cur_state (state_ff),
      .req_item  (in_data_ff),
      .nxt_state (state_in),
      .rsp_item  (step_rsp)
   );

   // a final byte may only move on once the result register has room
   assign advance = in_valid_ff &&
                    (!in_data_ff.last_byte || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && in_data_ff.last_byte) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= StateReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance && in_data_ff.last_byte) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `IPV6EHS_ASSERT_IMPLY(a_status_code, rsp_valid, (rsp_data.status == StOk || rsp_data.status == StTrunc || rsp_data.status == StNoNext), "result status is not a defined code")
   `IPV6EHS_ASSERT_IMPLY(a_err_fields_zero, (rsp_valid && rsp_data.status != StOk), (rsp_data.upper_protocol == 8'd0 && rsp_data.payload_offset == '0), "error result carries protocol or offset")
   `IPV6EHS_ASSERT_IMPLY(a_ok_offset_min, (rsp_valid && rsp_data.status == StOk), (rsp_data.payload_offset >= FixedHdrLen[OffsetBits-1:0]), "ok result offset below fixed header")
   `IPV6EHS_ASSERT(a_wait6_chain_pos, (state_ff.parse_phase != PhWait6 || state_ff.chain_pos == FixedHdrLen), "chain position moved before byte six")

endmodule

[sv/ipv6ehs_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6ehs_step
// Next-state and result logic for one packet byte of the header chain walk.
// ----------------------------------------------------------------------------
module ipv6ehs_step import ipv6ehs_pkg::*; (
   input  ipv6ehs_state_type cur_state,
   input  ipv6ehs_req_type   req_item,
   output ipv6ehs_state_type nxt_state,
   output ipv6ehs_rsp_type   rsp_item
);

   always_comb begin
      ipv6ehs_state_type    st;
      logic [11:0]          hdr_len;
      logic [OffsetBits+1:0] pos_sum;
      logic [OffsetBits+1:0] pos_plus1;
      logic [OffsetBits:0]  pkt_len;

      st        = cur_state;
      hdr_len   = 12'd0;
      pos_sum   = '0;
      pos_plus1 = (OffsetBits + 2)'(cur_state.chain_pos) + (OffsetBits + 2)'(1);
      rsp_item  = '0;

      if (cur_state.byte_index == MaxLen) begin
         st.sticky_error = StTrunc;
      end else if (cur_state.sticky_error == StOk) begin
         case (cur_state.parse_phase)
            PhWait6: begin
               if (cur_state.byte_index == NextHdrIndex) begin
                  st.current_type = req_item.pkt_byte;
                  st.parse_phase  = is_ext_type(req_item.pkt_byte) ? PhWaitType : PhDone;
               end
            end
            PhWaitType: begin
               if ({1'b0, cur_state.byte_index} == cur_state.chain_pos) begin
                  st.pending_type = req_item.pkt_byte;
                  st.parse_phase  = PhWaitLen;
               end
            end
            PhWaitLen: begin
               if ((OffsetBits + 2)'(cur_state.byte_index) == pos_plus1) begin
                  if (cur_state.current_type == NhNoNext) begin
                     st.sticky_error = StNoNext;
                  end else begin
                     if (cur_state.current_type == NhFragment) begin
                        hdr_len = 12'd8;
                     end else if (cur_state.current_type == NhAuth) begin
                        hdr_len = (12'(req_item.pkt_byte) + 12'd2) << 2;
                     end else begin
                        hdr_len = (12'(req_item.pkt_byte) + 12'd1) << 3;
                     end
                     pos_sum = (OffsetBits + 2)'(cur_state.chain_pos) +
                               (OffsetBits + 2)'(hdr_len);
                     // clamp just above the longest packet
                     if (pos_sum > (OffsetBits + 2)'(MaxLen)) begin
                        st.chain_pos = {1'b1, {OffsetBits{1'b0}}};
                     end else begin
                        st.chain_pos = pos_sum[OffsetBits:0];
                     end
                     st.current_type = cur_state.pending_type;
                     st.parse_phase  = is_ext_type(cur_state.pending_type) ?
                                       PhWaitType : PhDone;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (cur_state.byte_index != MaxLen) begin
         st.byte_index = cur_state.byte_index + OffsetBits'(1);
      end

      pkt_len = (OffsetBits + 1)'(cur_state.byte_index) + (OffsetBits + 1)'(1);
      if (st.sticky_error != StOk) begin
         rsp_item.status = st.sticky_error;
      end else if (st.parse_phase != PhDone) begin
         rsp_item.status = StTrunc;
      end else if (st.chain_pos != FixedHdrLen && st.chain_pos > pkt_len) begin
         rsp_item.status = StTrunc;
      end else begin
         rsp_item.status         = StOk;
         rsp_item.upper_protocol = st.current_type;
         rsp_item.payload_offset = st.chain_pos[OffsetBits-1:0];
      end

      // each packet starts from a clean walker
      nxt_state = req_item.last_byte ? StateReset : st;
   end

endmodule

[verif/tb_ipv6_extension_header_skipper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv6_extension_header_skipper
// Streams ipv6 packets byte by byte into the header skipper and checks each
// reported protocol, offset and status against a cycle-free model of the
// extension header walk, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_ipv6_extension_header_skipper;
   import ipv6ehs_pkg::*;

   localparam int unsigned CycleLimit = 1_000_000;
   localparam int unsigned RandomBytes = 1100;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   ipv6ehs_req_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   ipv6ehs_rsp_type rsp_data;

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   logic        stall_rsp_request = 1'b0;
   int unsigned random_bytes_sent = 0;
   int unsigned cycle_count = 0;

   // walks the header chain of each packet and queues the result it should give
   class ehs_scoreboard;
      logic [OffsetBits-1:0] byte_idx;
      logic [OffsetBits:0]   hdr_pos;
      logic [7:0]            next_type;
      logic [7:0]            hdr_type;
      logic [1:0]            phase;
      logic [1:0]            first_err;
      ipv6ehs_rsp_type       expected_results[$];
      int unsigned           failures;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         byte_idx  = '0;
         hdr_pos   = FixedHdrLen;
         next_type = 8'd0;
         hdr_type  = 8'd0;
         phase     = PhWait6;
         first_err = StOk;
      endfunction

      static function bit is_chain_type(logic [7:0] t);
         return t == NhHopByHop || t == NhRouting || t == NhFragment ||
                t == NhAuth || t == NhNoNext || t == NhDestOpts;
      endfunction

      static function int unsigned header_span(logic [7:0] t, logic [7:0] len);
         if (t == NhFragment) return 8;
         if (t == NhAuth) return (int'(len) + 2) * 4;
         return (int'(len) + 1) * 8;
      endfunction

      function void note_byte(ipv6ehs_req_type item);
         int unsigned     pkt_len;
         int unsigned     pos;
         ipv6ehs_rsp_type res;
         if (byte_idx == MaxLen) begin
            first_err = StTrunc;
         end else if (first_err == StOk) begin
            case (phase)
               PhWait6: begin
                  if (byte_idx == NextHdrIndex) begin
                     hdr_type = item.pkt_byte;
                     phase = is_chain_type(hdr_type) ? PhWaitType : PhDone;
                  end
               end
               PhWaitType: begin
                  if (int'(byte_idx) == int'(hdr_pos)) begin
                     next_type = item.pkt_byte;
                     phase = PhWaitLen;
                  end
               end
               PhWaitLen: begin
                  if (int'(byte_idx) == int'(hdr_pos) + 1) begin
                     if (hdr_type == NhNoNext) begin
                        first_err = StNoNext;
                     end else begin
                        pos = int'(hdr_pos) + header_span(hdr_type, item.pkt_byte);
                        // offset saturates just past the longest packet
                        if (pos > int'(MaxLen)) pos = int'(MaxLen) + 1;
                        hdr_pos = pos[OffsetBits:0];
                        hdr_type = next_type;
                        phase = is_chain_type(hdr_type) ? PhWaitType : PhDone;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         pkt_len = int'(byte_idx) + 1;
         if (byte_idx != MaxLen) byte_idx = byte_idx + 1'b1;
         if (!item.last_byte) return;
         res = '0;
         if (first_err != StOk) begin
            res.status = first_err;
         end else if (phase != PhDone) begin
            res.status = StTrunc;
         end else if (hdr_pos != FixedHdrLen && int'(hdr_pos) > pkt_len) begin
            res.status = StTrunc;
         end else begin
            res.status = StOk;
            res.upper_protocol = hdr_type;
            res.payload_offset = hdr_pos[OffsetBits-1:0];
         end
         expected_results.push_back(res);
         restart();
      endfunction

      function void check_result(ipv6ehs_rsp_type got);
         ipv6ehs_rsp_type want;
         if (expected_results.size() == 0) begin
            $error("result with no packet outstanding: status %0d", got.status);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.upper_protocol !== want.upper_protocol) begin
            $error("upper_protocol: expected %0d, got %0d",
                   want.upper_protocol, got.upper_protocol);
            failures++;
         end
         if (got.payload_offset !== want.payload_offset) begin
            $error("payload_offset: expected %0d, got %0d",
                   want.payload_offset, got.payload_offset);
            failures++;
         end
      endfunction
   endclass

   ehs_scoreboard sb = new();

   ipv6_extension_header_skipper u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      int unsigned held;
      forever begin
         @(negedge clock);
         if (stall_rsp_request) begin
            stall_rsp_request = 1'b0;
            for (held = 0; held < 400; held++) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic void add_random(ref logic [7:0] pkt[$], input int unsigned n);
      repeat (n) pkt.push_back(8'($urandom));
   endfunction

   function automatic void add_fixed(ref logic [7:0] pkt[$], input logic [7:0] first);
      add_random(pkt, 40);
      pkt[6] = first;
   endfunction

   function automatic void add_header(ref logic [7:0] pkt[$],
                                      input logic [7:0] kind, nxt, len);
      pkt.push_back(nxt);
      pkt.push_back(len);
      add_random(pkt, ehs_scoreboard::header_span(kind, len) - 2);
   endfunction

   function automatic logic [7:0] pick_chain_type();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5) return NhNoNext;
      case (r % 5)
         0: return NhHopByHop;
         1: return NhRouting;
         2: return NhFragment;
         3: return NhAuth;
         default: return NhDestOpts;
      endcase
   endfunction

   // mostly well-formed chains with random content, some cut short, some noise
   function automatic void make_random_packet(ref logic [7:0] pkt[$]);
      logic [7:0]  kinds[$];
      logic [7:0]  upper;
      logic [7:0]  len;
      int unsigned roll, n, j, cut;
      pkt.delete();
      roll = $urandom_range(99);
      if (roll < 15) begin
         add_random(pkt, $urandom_range(1, 60));
         if (pkt.size() > 6 && $urandom_range(1) == 1) pkt[6] = pick_chain_type();
         return;
      end
      do upper = 8'($urandom); while (ehs_scoreboard::is_chain_type(upper));
      n = $urandom_range(0, 4);
      for (j = 0; j < n; j++) kinds.push_back(pick_chain_type());
      add_fixed(pkt, n > 0 ? kinds[0] : upper);
      for (j = 0; j < n; j++) begin
         len = ($urandom_range(99) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
         add_header(pkt, kinds[j], j + 1 < n ? kinds[j + 1] : upper, len);
         if (kinds[j] == NhNoNext) break;
      end
      add_random(pkt, $urandom_range(0, 12));
      if (roll < 30) begin
         cut = $urandom_range(1, pkt.size());
         while (pkt.size() > cut) void'(pkt.pop_back());
      end
   endfunction

   task automatic send_byte(input ipv6ehs_req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_packet(input logic [7:0] pkt[$]);
      ipv6ehs_req_type item;
      int unsigned     k;
      for (k = 0; k < pkt.size(); k++) begin
         item.pkt_byte  = pkt[k];
         item.last_byte = (k == pkt.size() - 1);
         send_byte(item);
      end
   endtask

   initial begin
      logic [7:0]  pkt[$];
      int unsigned p, n, phase_pkts;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // packets ending before the next-header byte
      pkt.delete(); pkt.push_back(8'hff);
      send_packet(pkt);
      pkt.delete(); add_random(pkt, 6);
      send_packet(pkt);
      // no extension headers, even when shorter than the fixed header
      pkt.delete(); add_random(pkt, 7); pkt[6] = 8'd6;
      send_packet(pkt);
      pkt.delete(); add_fixed(pkt, 8'd17);
      send_packet(pkt);
      pkt.delete(); add_fixed(pkt, 8'hff); add_random(pkt, 1);
      send_packet(pkt);
      // every extension type but no next header in one chain
      pkt.delete(); add_fixed(pkt, NhHopByHop);
      add_header(pkt, NhHopByHop, NhRouting, 8'd0);
      add_header(pkt, NhRouting, NhFragment, 8'd1);
      add_header(pkt, NhFragment, NhAuth, 8'hff);
      add_header(pkt, NhAuth, NhDestOpts, 8'd0);
      add_header(pkt, NhDestOpts, 8'd6, 8'd0);
      add_random(pkt, 4);
      send_packet(pkt);
      // no next header, with and without its length byte present
      pkt.delete(); add_fixed(pkt, NhNoNext); add_random(pkt, 2);
      send_packet(pkt);
      pkt.delete(); add_fixed(pkt, NhNoNext); add_random(pkt, 1);
      send_packet(pkt);
      // extension header cut before its leading bytes
      pkt.delete(); add_fixed(pkt, NhHopByHop);
      send_packet(pkt);
      // header overrun, then a header ending exactly at the packet end
      pkt.delete(); add_fixed(pkt, NhHopByHop);
      add_header(pkt, NhHopByHop, 8'd17, 8'd1);
      void'(pkt.pop_back());
      send_packet(pkt);
      pkt.delete(); add_fixed(pkt, NhDestOpts);
      add_header(pkt, NhDestOpts, 8'd58, 8'd0);
      send_packet(pkt);
      // largest header lengths, packet ending right after the length byte
      pkt.delete(); add_fixed(pkt, NhAuth);
      pkt.push_back(8'd17); pkt.push_back(8'hff);
      send_packet(pkt);
      pkt.delete(); add_fixed(pkt, NhHopByHop);
      pkt.push_back(NhNoNext); pkt.push_back(8'hff);
      send_packet(pkt);
      // no next header behind a first extension header
      pkt.delete(); add_fixed(pkt, NhHopByHop);
      add_header(pkt, NhHopByHop, NhNoNext, 8'd1);
      add_header(pkt, NhNoNext, 8'd6, 8'd0);
      add_random(pkt, 20);
      send_packet(pkt);

      // long receiver hold-off so the input side backs up
      stall_rsp_request = 1'b1;
      for (p = 0; p < 24; p++) begin
         pkt.delete(); add_random(pkt, $urandom_range(1, 8));
         send_packet(pkt);
      end

      for (p = 0; p < 3; p++) begin
         req_idle_pct = (p == 0) ? 35 : (p == 1) ? 50 : 0;
         rsp_idle_pct = (p == 0) ? 50 : (p == 1) ? 35 : 0;
         phase_pkts = 0;
         while (random_bytes_sent < RandomBytes * (p + 1) / 3 || phase_pkts < 4) begin
            make_random_packet(pkt);
            n = pkt.size();
            send_packet(pkt);
            random_bytes_sent += n;
            phase_pkts++;
         end
      end
      req_valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[ipv6_extension_header_skipper.f]
+incdir+sv
sv/ipv6ehs_pkg.sv
sv/ipv6ehs_step.sv
sv/ipv6_extension_header_skipper.sv
verif/tb_ipv6_extension_header_skipper.sv
